/* hw/rtl/masked_dense_to_coo_compactor_macros.svh */
// Assertion macros shared by the dense-to-COO compactor RTL.
// Each macro expects clk and rst to be in scope where it is used.
`ifndef MASKED_DENSE_TO_COO_COMPACTOR_MACROS_SVH
`define MASKED_DENSE_TO_COO_COMPACTOR_MACROS_SVH

// same-cycle implication
`define MDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mdc_pkg.sv */
// Types, constants and helpers for the dense-to-COO compactor.
// No dependencies; used by mdc_lane, mdc_merge and the top level.
package mdc_pkg;

  localparam int LANES_MAX = 4;

  localparam logic [16:0] MAX_COLS = 17'd65536;
  localparam logic [16:0] MAX_ROWS = 17'd65536;
  localparam logic [16:0] RESET_COUNT = 17'd64;

  localparam logic [1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [1:0] CFG_NUM_ROWS = 2'd1;

  typedef struct packed {
    logic        keep;
    logic [15:0] col;
  } lane_res_t;

  typedef struct packed {
    logic [LANES_MAX-1:0][31:0] vals;
    logic [LANES_MAX-1:0][15:0] cols;
    logic [2:0]                 kept_count;
    logic [31:0]                write_base;
    logic [15:0]                row_index;
    logic                       row_end;
  } res_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [16:0] clamp_count(input logic [16:0] v, input logic [16:0] hi);
    logic [16:0] r;
    if (v == 17'd0) begin
      r = 17'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mdc_lane.sv */
// One element lane: column of the element and its keep decision.
// Depends on mdc_pkg.
module mdc_lane (
  input  logic              lane_en,
  input  logic [1:0]        lane_idx,
  input  logic [15:0]       col_base,
  input  logic [16:0]       num_cols,
  input  logic [7:0]        mask,
  output mdc_pkg::lane_res_t res
);
  import mdc_pkg::*;

  logic [16:0] col;

  assign col      = {1'b0, col_base} + {15'b0, lane_idx};
  assign res.keep = lane_en && (col < num_cols) && (mask != 8'd0);
  assign res.col  = col[15:0];

endmodule

/* hw/rtl/mdc_merge.sv */
// Packs kept lanes into the low result slots in column order.
// Depends on mdc_pkg.
module mdc_merge (
  input  mdc_pkg::lane_res_t [mdc_pkg::LANES_MAX-1:0]        lanes,
  input  logic [mdc_pkg::LANES_MAX-1:0][31:0]                values,
  output logic [2:0]                                         kept_count,
  output logic [mdc_pkg::LANES_MAX-1:0][15:0]                cols,
  output logic [mdc_pkg::LANES_MAX-1:0][31:0]                vals
);
  import mdc_pkg::*;

  always_comb begin
    logic [2:0] cnt;
    cnt  = 3'd0;
    cols = '0;
    vals = '0;
    for (int i = 0; i < LANES_MAX; i++) begin
      if (lanes[i].keep) begin
        cols[cnt[1:0]] = lanes[i].col;
        vals[cnt[1:0]] = values[i];
        cnt = cnt + 3'd1;
      end
    end
    kept_count = cnt;
  end

endmodule

/* hw/rtl/masked_dense_to_coo_compactor.sv */
// Dense-to-COO compactor: takes four-element chunks of a row-major matrix
// and gives one result per chunk with the kept elements packed to the low
// lanes, their row and column indices, and the running COO write position.
// One chunk is accepted every cycle while s_tready is high; its result goes
// to the output register, or to the skid register when the output is full
// and stalled, so the skid holds one more result. num_cols and num_rows take
// effect for the next chunk; there is no clearing pass after reset.
// Depends on mdc_pkg, mdc_lane, mdc_merge and the macros header.
module masked_dense_to_coo_compactor #(
  parameter int LANES = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // value_0, value_1, value_2, value_3, mask_0, mask_1, mask_2, mask_3
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // row_index, write_base, kept_count, col_out_0..3, val_out_0..3, 5 zero bits
  output logic [247:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import mdc_pkg::*;

  logic [16:0] num_cols;
  logic [16:0] num_rows;
  logic [15:0] current_row;
  logic [15:0] current_col;
  logic [31:0] kept_total;

  logic        s_accept;
  logic        m_take;
  logic        row_end;
  logic        matrix_end;
  logic [16:0] row_inc;
  logic [16:0] col_inc;

  lane_res_t [LANES_MAX-1:0]   lane_res;
  logic [LANES_MAX-1:0][31:0]  values;
  logic [2:0]                  kept_count;
  logic [LANES_MAX-1:0][15:0]  cols;
  logic [LANES_MAX-1:0][31:0]  vals;
  res_t                        res_new;

  res_t out_res;
  res_t skid_res;
  logic out_valid;
  logic skid_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign s_accept  = s_tvalid && s_tready;
  assign m_take    = out_valid && m_tready;

  genvar gi;
  generate
    for (gi = 0; gi < LANES_MAX; gi++) begin : g_lane
      assign values[gi] = s_tdata[32*gi +: 32];
      mdc_lane u_lane (
        .lane_en  (gi < LANES),
        .lane_idx (2'(gi)),
        .col_base (current_col),
        .num_cols (num_cols),
        .mask     (s_tdata[128 + 8*gi +: 8]),
        .res      (lane_res[gi])
      );
    end
  endgenerate

  mdc_merge u_merge (
    .lanes      (lane_res),
    .values     (values),
    .kept_count (kept_count),
    .cols       (cols),
    .vals       (vals)
  );

  assign col_inc    = {1'b0, current_col} + 17'(LANES);
  assign row_inc    = {1'b0, current_row} + 17'd1;
  assign row_end    = col_inc >= num_cols;
  assign matrix_end = row_inc >= num_rows;

  always_comb begin
    res_new.vals       = vals;
    res_new.cols       = cols;
    res_new.kept_count = kept_count;
    res_new.write_base = kept_total;
    res_new.row_index  = current_row;
    res_new.row_end    = row_end;
  end

  // configuration, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= RESET_COUNT;
      num_rows <= RESET_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_COLS: num_cols <= clamp_count(cfg_data, MAX_COLS);
        CFG_NUM_ROWS: num_rows <= clamp_count(cfg_data, MAX_ROWS);
        default: ;
      endcase
    end
  end

  // row / column / write position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= 16'd0;
      current_col <= 16'd0;
      kept_total  <= 32'd0;
    end else if (s_accept) begin
      if (row_end) begin
        current_col <= 16'd0;
        if (matrix_end) begin
          current_row <= 16'd0;
          kept_total  <= 32'd0;
        end else begin
          current_row <= row_inc[15:0];
          kept_total  <= kept_total + {29'd0, kept_count};
        end
      end else begin
        current_col <= col_inc[15:0];
        kept_total  <= kept_total + {29'd0, kept_count};
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (m_take && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (m_take) begin
        out_valid <= s_accept;
      end else if (s_accept && out_valid) begin
        skid_valid <= 1'b1;
      end else if (s_accept) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (m_take && skid_valid) begin
      out_res <= skid_res;
    end else if (s_accept && (m_take || !out_valid)) begin
      out_res <= res_new;
    end else if (s_accept) begin
      skid_res <= res_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.row_end;
  assign m_tdata  = {5'd0,
                     out_res.vals[3], out_res.vals[2], out_res.vals[1], out_res.vals[0],
                     out_res.cols[3], out_res.cols[2], out_res.cols[1], out_res.cols[0],
                     out_res.kept_count, out_res.write_base, out_res.row_index};

`include "masked_dense_to_coo_compactor_macros.svh"

  `MDC_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid full with empty output")
  `MDC_ASSERT_NOW(a_kept_bound, out_valid, out_res.kept_count <= 3'(LANES), "kept_count too big")
  `MDC_ASSERT_NEXT(a_row_end_col, s_accept && row_end, current_col == 16'd0, "col not cleared")
  `MDC_ASSERT_NEXT(a_col_step, s_accept && !row_end, current_col == $past(col_inc[15:0]), "bad col step")
  `MDC_ASSERT_NEXT(a_matrix_wrap, s_accept && row_end && matrix_end, (current_row == 16'd0) && (kept_total == 32'd0), "matrix wrap missed")

endmodule
